// ----- design/dcps_pkg.sv -----
package dcps_pkg;

    // timestamp and voltage arithmetic widths
    localparam int TIME_BITS    = 32;
    localparam int VOLTAGE_BITS = 12;

    // configuration register widths and reset values
    localparam int THRESHOLD_W   = 12;
    localparam int TIMEOUT_W     = 16;
    localparam int STABLE_W      = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = THRESHOLD_W'(600);
    localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RESET   = TIMEOUT_W'(10000);
    localparam logic [STABLE_W-1:0]    STABLE_RESET    = STABLE_W'(500);

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_VOLTAGE_THRESHOLD = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_PRECHARGE_TIMEOUT = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_STABLE_TIME       = CFG_INDEX_W'(2);

    // one control tick
    typedef struct packed {
        logic [31:0] tick_time;
        logic [11:0] bus_voltage;
        logic        fault_line;
        logic        start_request;
        logic        reset_request;
    } tick_word_t;

    // one result
    typedef struct packed {
        logic [1:0] mode_now;
        logic       precharge_contactor;
        logic       main_contactor;
    } result_word_t;

    // configuration seen by the sequencer
    typedef struct packed {
        logic [THRESHOLD_W-1:0] voltage_threshold;
        logic [TIMEOUT_W-1:0]   precharge_timeout;
        logic [STABLE_W-1:0]    stable_time;
    } cfg_t;

endpackage

// ----- design/dcps_cfg_regs.sv -----
module dcps_cfg_regs
    import dcps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register decode, unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_VOLTAGE_THRESHOLD: cfg_next.voltage_threshold = cfg_data[THRESHOLD_W-1:0];
                CFG_PRECHARGE_TIMEOUT: cfg_next.precharge_timeout = cfg_data[TIMEOUT_W-1:0];
                CFG_STABLE_TIME:       cfg_next.stable_time       = cfg_data[STABLE_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.voltage_threshold <= THRESHOLD_RESET;
            cfg_reg.precharge_timeout <= TIMEOUT_RESET;
            cfg_reg.stable_time       <= STABLE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/dcps_seq_core.sv -----
module dcps_seq_core
    import dcps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         advance,
    input  tick_word_t   tick,
    output result_word_t result
);

    typedef enum logic [1:0] {
        ST_IDLE      = 2'd0,
        ST_PRECHARGE = 2'd1,
        ST_RUN       = 2'd2,
        ST_FAULT     = 2'd3
    } seq_state_t;

    seq_state_t             state_reg, state_next, state_eff;
    logic [TIME_BITS-1:0]   precharge_begin_reg, precharge_begin_next;
    logic [TIME_BITS-1:0]   stable_begin_reg, stable_begin_next;
    logic                   reached_reg, reached_next;
    logic                   start_pending_reg, start_pending_next;
    logic                   reset_pending_reg, reset_pending_next;

    logic [TIME_BITS-1:0]    now;
    logic [VOLTAGE_BITS-1:0] volts;
    logic [VOLTAGE_BITS-1:0] threshold;
    logic [TIME_BITS-1:0]    stable_ref;
    logic [TIME_BITS-1:0]    precharge_elapsed;
    logic [TIME_BITS-1:0]    stable_elapsed;
    logic                    timed_out;
    logic                    stable_done;
    logic                    volts_reached;
    logic                    pc;
    logic                    mc;

    assign now       = TIME_BITS'(tick.tick_time);
    assign volts     = VOLTAGE_BITS'(tick.bus_voltage);
    assign threshold = VOLTAGE_BITS'(cfg.voltage_threshold);

    // wrapping elapsed times and threshold compares
    assign stable_ref        = reached_reg ? stable_begin_reg : now;
    assign precharge_elapsed = now - precharge_begin_reg;
    assign stable_elapsed    = now - stable_ref;
    assign timed_out     = precharge_elapsed >= TIME_BITS'(cfg.precharge_timeout);
    assign stable_done   = stable_elapsed >= TIME_BITS'(cfg.stable_time);
    assign volts_reached = volts >= threshold;

    // next state for the tick at the input register
    always_comb
    begin
        start_pending_next   = start_pending_reg | tick.start_request;
        reset_pending_next   = reset_pending_reg | tick.reset_request;
        state_eff            = tick.fault_line ? ST_FAULT : state_reg;
        state_next           = state_eff;
        precharge_begin_next = precharge_begin_reg;
        stable_begin_next    = stable_begin_reg;
        reached_next         = reached_reg;
        pc                   = 1'b0;
        mc                   = 1'b0;
        unique case (state_eff)
            ST_IDLE:
            begin
                if (start_pending_next)
                begin
                    state_next           = ST_PRECHARGE;
                    precharge_begin_next = now;
                    start_pending_next   = 1'b0;
                    reached_next         = 1'b0;
                end
            end
            ST_PRECHARGE:
            begin
                pc = 1'b1;
                if (timed_out)
                begin
                    state_next = ST_FAULT;
                end
                else if (volts_reached)
                begin
                    reached_next      = 1'b1;
                    stable_begin_next = stable_ref;
                    if (stable_done)
                    begin
                        state_next   = ST_RUN;
                        reached_next = 1'b0;
                    end
                end
                else
                begin
                    reached_next = 1'b0;
                end
            end
            ST_RUN:
            begin
                mc = 1'b1;
            end
            default:
            begin
                if (reset_pending_next)
                begin
                    state_next         = ST_IDLE;
                    reset_pending_next = 1'b0;
                end
            end
        endcase
    end

    assign result.mode_now            = state_next;
    assign result.precharge_contactor = pc;
    assign result.main_contactor      = mc;

    // sequencer state, updated once per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            precharge_begin_reg <= '0;
            stable_begin_reg    <= '0;
            reached_reg         <= 1'b0;
            start_pending_reg   <= 1'b0;
            reset_pending_reg   <= 1'b0;
        end
        else if (advance)
        begin
            state_reg           <= state_next;
            precharge_begin_reg <= precharge_begin_next;
            stable_begin_reg    <= stable_begin_next;
            reached_reg         <= reached_next;
            start_pending_reg   <= start_pending_next;
            reset_pending_reg   <= reset_pending_next;
        end
    end

`ifndef ASSERT_OFF
    // a fault with no reset waiting always lands in fault
    a_fault_wins: assert property (@(posedge clk) disable iff (!rst_n)
        advance && tick.fault_line && !reset_pending_reg && !tick.reset_request
        |=> state_reg == ST_FAULT)
        else $error("fault did not force fault state");

    // run is only entered from precharge
    a_run_from_precharge: assert property (@(posedge clk) disable iff (!rst_n)
        advance && state_next == ST_RUN && state_reg != ST_RUN
        |-> state_reg == ST_PRECHARGE && !tick.fault_line)
        else $error("run entered from outside precharge");

    // stability tracking is clear whenever precharge starts
    a_reached_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        advance && state_reg == ST_IDLE && state_next == ST_PRECHARGE
        |=> !reached_reg && precharge_begin_reg == $past(now))
        else $error("precharge entry left stale tracking");
`endif

endmodule

// ----- design/dc_bus_precharge_sequencer_top.sv -----
// channel  | handshake               | payload
// ---------+-------------------------+---------------------------------
// tick     | tick_valid / tick_stall | tick_word (tick_word_t)
// result   | result_valid / result_stall | result_word (result_word_t)
// config   | cfg_write               | cfg_index, cfg_data
//
// one word per cycle while result_stall is low; a taken tick passes from the input
// register through the core into the result register, which drives result_valid.
// the only loop is the sequencer state register.
// rst_n clears the state, pending requests and both valids, and resets the config.
// result_stall holds the result register; the input register keeps taking a
// word as long as the result register can move on in the same cycle.
module dc_bus_precharge_sequencer_top
    import dcps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   tick_valid,
    output logic                   tick_stall,
    input  tick_word_t             tick_word,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_word_t           result_word,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t         cfg;
    tick_word_t   tick_reg;
    logic         tick_valid_reg;
    result_word_t result_reg;
    logic         result_valid_reg;
    result_word_t result_next;
    logic         advance;
    logic         take;

    dcps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dcps_seq_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .tick    (tick_reg),
        .result  (result_next)
    );

    // pipeline flow control
    assign advance    = tick_valid_reg && (!result_valid_reg || !result_stall);
    assign tick_stall = tick_valid_reg && !advance;
    assign take       = tick_valid && !tick_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
        end
        else if (!tick_stall)
        begin
            tick_valid_reg <= tick_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tick_reg <= tick_word;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (!result_valid_reg || !result_stall)
        begin
            result_valid_reg <= tick_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_word  = result_reg;

`ifndef ASSERT_OFF
    // a held word moves on when the result register is free
    a_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid_reg && !result_valid_reg |=> result_valid_reg)
        else $error("word stuck in input register");

    // stalling upstream only with a word held
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        tick_stall |-> tick_valid_reg && result_valid_reg && result_stall)
        else $error("tick stalled without cause");

    // contactors never closed together
    a_contactors: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(result_reg.precharge_contactor && result_reg.main_contactor))
        else $error("both contactors driven");
`endif

endmodule
